// ----- sv/btw_pkg.sv -----
// package for the boot image tlv dependency walker
// types, constants and result record shared by the front, queue and top level; no dependencies
`default_nettype none
package btw_pkg;
    localparam int MaxEntriesDefault = 64;
    localparam logic [15:0] MagicUnprot = 16'h6907;
    localparam logic [15:0] MagicProt = 16'h6908;
    localparam logic [15:0] TypeDep = 16'h0040;
    localparam logic [32:0] HdrBytes = 33'd4;
    localparam logic [15:0] DepBytes = 16'd12;

    localparam logic [1:0] RegHeaderSize = 2'd0;
    localparam logic [1:0] RegPayloadSize = 2'd1;
    localparam logic [1:0] RegProtSize = 2'd2;
    localparam logic [1:0] RegImageLength = 2'd3;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NO_AREA = 3'd1, ST_PROT_SIZE = 3'd2, ST_NO_UNPROT = 3'd3,
        ST_PAST_END = 3'd4, ST_TOO_MANY = 3'd5, ST_OVERRUN = 3'd6, ST_BAD_LEN = 3'd7
    } t_status;

    // one result record, as queued between front and back
    typedef struct packed {
        logic        kind;
        logic [7:0]  dep_image;
        logic [7:0]  min_major;
        logic [7:0]  min_minor;
        logic [15:0] min_revision;
        logic [31:0] min_build;
        logic [2:0]  status;
        logic        last;
    } t_result;
endpackage
`default_nettype wire

// ----- sv/btw_front.sv -----
// front part: byte counter, area header checks and entry walk
// depends on btw_pkg; emits up to two result records per byte
`default_nettype none
module btw_front #(
    parameter int MAX_ENTRIES = btw_pkg::MaxEntriesDefault
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [7:0]            i_byte,
    input  wire logic [15:0]           i_header_size,
    input  wire logic [31:0]           i_payload_size,
    input  wire logic [15:0]           i_prot_size,
    input  wire logic [31:0]           i_image_length,
    output logic                       o_rec_valid,
    output btw_pkg::t_result           o_rec,
    output logic                       o_fin_valid,
    output btw_pkg::t_result           o_fin
);
    import btw_pkg::*;
    localparam int EW = $clog2(MAX_ENTRIES + 1) + 1;
    localparam logic [EW-1:0] MaxE = EW'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        PH_FIRST = 4'b0001, PH_SECOND = 4'b0010, PH_READY = 4'b0100, PH_FAILED = 4'b1000
    } t_phase;
    typedef enum logic [2:0] {W_OFF = 3'b001, W_HDR = 3'b010, W_VAL = 3'b100} t_walk;

    logic [32:0] r_off, n_off, r_next, n_next, r_pend, n_pend;
    logic [32:0] r_pend_end, n_pend_end, r_area_end, n_area_end;
    t_phase r_phase, n_phase;
    t_walk r_walk, n_walk;
    logic [15:0] r_etype, n_etype, r_elen, n_elen;
    logic [EW-1:0] r_seen, n_seen;
    logic [2:0] r_err, n_err;
    logic [31:0] r_aw, n_aw;
    logic r_prot, n_prot, r_pv, n_pv, r_pbad, n_pbad, r_fin, n_fin;
    logic [7:0] r_val [12];
    logic [3:0] val_idx;
    logic val_we;

    // scratch
    logic [32:0] base, start, eend, at, d_ent, d_val;
    logic [31:0] aw;
    logic hit;
    logic [1:0] idx;
    logic known, dep, ok_len, stop;

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0; r_next <= '0; r_pend <= '0; r_area_end <= '0;
            r_phase <= PH_FIRST; r_walk <= W_OFF; r_seen <= '0; r_err <= '0;
            r_prot <= 1'b0; r_pv <= 1'b0; r_pbad <= 1'b0; r_fin <= 1'b0;
        end else begin
            r_off <= n_off; r_next <= n_next; r_pend <= n_pend;
            r_area_end <= n_area_end; r_phase <= n_phase; r_walk <= n_walk;
            r_seen <= n_seen; r_err <= n_err; r_prot <= n_prot; r_pv <= n_pv;
            r_pbad <= n_pbad; r_fin <= n_fin;
        end
    end
    // payload registers; r_pend holds the end of the protected area
    always_ff @(posedge i_clk) begin
        r_etype <= n_etype; r_elen <= n_elen; r_aw <= n_aw; r_pend_end <= n_pend_end;
        if (val_we) r_val[val_idx] <= i_byte;
    end

    // per-byte update
    always_comb begin
        n_off = r_off; n_next = r_next; n_pend = r_pend; n_area_end = r_area_end;
        n_phase = r_phase; n_walk = r_walk; n_seen = r_seen; n_err = r_err;
        n_prot = r_prot; n_pv = r_pv; n_pbad = r_pbad; n_fin = r_fin;
        n_etype = r_etype; n_elen = r_elen; n_aw = r_aw; n_pend_end = r_pend_end;
        o_rec_valid = 1'b0; o_fin_valid = 1'b0; o_rec = '0; o_fin = '0;
        val_we = 1'b0; val_idx = '0;
        base = 33'(i_header_size) + 33'(i_payload_size);
        start = (r_phase == PH_FIRST) ? base : r_pend;
        aw = r_aw; idx = '0; at = r_next; eend = '0; known = 1'b0; dep = 1'b0;
        ok_len = 1'b0; stop = 1'b0; hit = 1'b0;
        d_ent = r_off - r_next;
        d_val = r_off - r_next - HdrBytes;
        if (i_valid && !r_fin && (r_off < 33'(i_image_length))) begin
            // area header bytes
            hit = ((r_phase == PH_FIRST) || (r_phase == PH_SECOND)) &&
                  (r_off >= start) && (r_off - start <= 33'd3);
            if (hit) begin
                idx = 2'(r_off - start);
                if (idx == 2'd0) aw = '0;
                aw = aw | (32'(i_byte) << {idx, 3'b000});
                n_aw = aw;
                if (idx == 2'd3) begin
                    if (r_phase == PH_FIRST) begin
                        if (aw[15:0] == MagicProt) begin
                            if (aw[31:16] != i_prot_size || aw[31:16] < 16'd4) begin
                                n_err = ST_PROT_SIZE; n_phase = PH_FAILED;
                                n_walk = W_OFF; n_pv = 1'b0;
                            end else begin
                                n_prot = 1'b1; n_pend = base + 33'(aw[31:16]);
                                n_phase = PH_SECOND;
                            end
                        end else if (aw[15:0] != MagicUnprot || i_prot_size != 16'd0) begin
                            n_err = ST_NO_AREA; n_phase = PH_FAILED;
                            n_walk = W_OFF; n_pv = 1'b0;
                        end else begin
                            n_prot = 1'b0; n_pend = base;
                            if (aw[31:16] < 16'd4 ||
                                33'(aw[31:16]) > 33'(i_image_length) - base) begin
                                n_err = ST_PAST_END; n_phase = PH_FAILED;
                                n_walk = W_OFF; n_pv = 1'b0;
                            end else begin
                                n_area_end = base + 33'(aw[31:16]); n_phase = PH_READY;
                            end
                        end
                        if (n_phase != PH_FAILED) begin
                            n_walk = W_HDR; n_next = base + HdrBytes; n_seen = '0;
                        end
                    end else begin
                        if (aw[15:0] != MagicUnprot) begin
                            n_err = ST_NO_UNPROT; n_phase = PH_FAILED;
                            n_walk = W_OFF; n_pv = 1'b0;
                        end else if (aw[31:16] < 16'd4 ||
                                33'(aw[31:16]) > 33'(i_image_length) - r_pend) begin
                            n_err = ST_PAST_END; n_phase = PH_FAILED;
                            n_walk = W_OFF; n_pv = 1'b0;
                        end else begin
                            n_area_end = r_pend + 33'(aw[31:16]); n_phase = PH_READY;
                            if (r_pv) begin
                                n_pv = 1'b0;
                                if (r_pend_end > n_area_end) begin
                                    if (n_err == ST_OK) n_err = ST_OVERRUN;
                                    n_walk = W_OFF;
                                end else if (r_pbad) begin
                                    if (n_err == ST_OK) n_err = ST_BAD_LEN;
                                    n_walk = W_OFF;
                                end
                            end
                        end
                    end
                end
            end
            // entry walk (uses state after area header handling)
            if (r_walk == W_HDR && n_walk == W_HDR && r_off >= r_next &&
                d_ent <= 33'd3) begin
                unique case (d_ent[1:0])
                    2'd0: n_etype = {8'h00, i_byte};
                    2'd1: n_etype = {i_byte, r_etype[7:0]};
                    2'd2: n_elen = {8'h00, i_byte};
                    default: begin
                        n_elen = {i_byte, r_elen[7:0]};
                        known = (n_phase == PH_READY);
                        eend = at + HdrBytes + 33'(n_elen);
                        dep = (r_etype == TypeDep);
                        ok_len = (n_elen == DepBytes);
                        if (known && at >= n_area_end) begin
                            n_walk = W_OFF; stop = 1'b1;
                        end else if (r_seen >= MaxE) begin
                            if (n_err == ST_OK) n_err = ST_TOO_MANY;
                            n_walk = W_OFF; n_pv = 1'b0; stop = 1'b1;
                        end else if (n_prot && at == n_pend) begin
                            n_seen = r_seen + 1'b1; n_next = at + HdrBytes; stop = 1'b1;
                        end else if (known) begin
                            if (at + HdrBytes > n_area_end || eend > n_area_end) begin
                                if (n_err == ST_OK) n_err = ST_OVERRUN;
                                n_walk = W_OFF; n_pv = 1'b0; stop = 1'b1;
                            end else if (dep && !ok_len) begin
                                if (n_err == ST_OK) n_err = ST_BAD_LEN;
                                n_walk = W_OFF; n_pv = 1'b0; stop = 1'b1;
                            end
                        end else if (eend > n_pend + HdrBytes) begin
                            n_pv = 1'b1; n_pend_end = eend; n_pbad = dep && !ok_len;
                        end else if (dep && !ok_len) begin
                            if (n_err == ST_OK) n_err = ST_BAD_LEN;
                            n_walk = W_OFF; n_pv = 1'b0; stop = 1'b1;
                        end
                        if (!stop) begin
                            n_seen = r_seen + 1'b1;
                            if (dep && ok_len) n_walk = W_VAL;
                            else n_next = eend;
                        end
                    end
                endcase
            end else if (r_walk == W_VAL && n_walk == W_VAL &&
                         r_off >= r_next + HdrBytes && d_val <= 33'd11) begin
                val_we = 1'b1; val_idx = d_val[3:0];
                if (d_val[3:0] == 4'd11) begin
                    o_rec_valid = 1'b1;
                    o_rec.dep_image = r_val[0];
                    o_rec.min_major = r_val[4];
                    o_rec.min_minor = r_val[5];
                    o_rec.min_revision = {r_val[7], r_val[6]};
                    o_rec.min_build = {i_byte, r_val[10], r_val[9], r_val[8]};
                    n_next = r_next + HdrBytes + 33'(DepBytes);
                    n_walk = W_HDR;
                end
            end
            // final status after the last byte
            n_off = r_off + 1'b1;
            if (n_off == 33'(i_image_length)) begin
                if (n_phase == PH_FIRST) begin
                    n_err = ST_NO_AREA; n_phase = PH_FAILED; n_walk = W_OFF;
                end else if (n_phase == PH_SECOND) begin
                    n_err = ST_NO_UNPROT; n_phase = PH_FAILED; n_walk = W_OFF;
                end else if (n_phase == PH_READY && n_walk == W_HDR && n_err == ST_OK &&
                             n_next < n_area_end) begin
                    n_err = (n_seen >= MaxE) ? ST_TOO_MANY : ST_OVERRUN;
                    n_walk = W_OFF;
                end
                n_fin = 1'b1;
                o_fin_valid = 1'b1; o_fin.kind = 1'b1; o_fin.status = n_err;
                o_fin.last = 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/btw_queue.sv -----
// result queue between front and back; two writes per cycle, one read
// depends on btw_pkg
`default_nettype none
module btw_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr0,
    input  wire btw_pkg::t_result  i_d0,
    input  wire logic              i_wr1,
    input  wire btw_pkg::t_result  i_d1,
    input  wire logic              i_rd,
    output btw_pkg::t_result       o_q,
    output logic                   o_empty,
    output logic                   o_almost_full
);
    import btw_pkg::*;
    localparam int AW = $clog2(DEPTH);
    t_result r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt, n_cnt;
    logic [AW-1:0] wp1;

    assign wp1 = r_wp + (i_wr0 ? AW'(1) : AW'(0));
    assign o_q = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    // room for two more records must be left before the next byte
    assign o_almost_full = (r_cnt > (AW+1)'(DEPTH - 2));
    assign n_cnt = r_cnt + (AW+1)'(i_wr0) + (AW+1)'(i_wr1) - (AW+1)'(i_rd && !o_empty);

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= wp1 + (i_wr1 ? AW'(1) : AW'(0));
            if (i_rd && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end
    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr0) r_mem[r_wp] <= i_d0;
        if (i_wr1) r_mem[wp1] <= i_d1;
    end
endmodule
`default_nettype wire

// ----- sv/boot_image_tlv_dependency_walker.sv -----
// top level: config registers, byte front end and result queue
// depends on btw_pkg, btw_front, btw_queue
//
// channel  | direction | handshake       | payload
// input    | in        | push / full     | i_data_byte
// result   | out       | empty / pop     | o_result_kind .. o_is_last
// config   | in        | i_cfg_we        | i_cfg_index, i_cfg_data
//
// one byte per cycle while full is low; each byte is classified in the cycle it is taken
// a byte gives at most two results, placed in a four-entry queue
// full rises when fewer than two queue slots are free
// synchronous active-low reset; no clearing pass
`default_nettype none
module boot_image_tlv_dependency_walker #(
    parameter int MAX_ENTRIES = btw_pkg::MaxEntriesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_result_kind,
    output logic [7:0]       o_dep_image,
    output logic [7:0]       o_min_major,
    output logic [7:0]       o_min_minor,
    output logic [15:0]      o_min_revision,
    output logic [31:0]      o_min_build,
    output logic [2:0]       o_parse_status,
    output logic             o_is_last,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import btw_pkg::*;
    logic [15:0] r_header_size, r_prot_size;
    logic [31:0] r_payload_size, r_image_length;
    logic rec_v, fin_v, acc;
    t_result rec, fin, q;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_size <= '0; r_payload_size <= '0;
            r_prot_size <= '0; r_image_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegHeaderSize:  r_header_size <= i_cfg_data[15:0];
                RegPayloadSize: r_payload_size <= i_cfg_data;
                RegProtSize:    r_prot_size <= i_cfg_data[15:0];
                default:        r_image_length <= i_cfg_data;
            endcase
        end
    end

    assign acc = push && !full;

    btw_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .i_clk, .i_rst_n, .i_valid(acc), .i_byte(i_data_byte),
        .i_header_size(r_header_size), .i_payload_size(r_payload_size),
        .i_prot_size(r_prot_size), .i_image_length(r_image_length),
        .o_rec_valid(rec_v), .o_rec(rec), .o_fin_valid(fin_v), .o_fin(fin)
    );

    btw_queue #(.DEPTH(4)) u_queue (
        .i_clk, .i_rst_n, .i_wr0(rec_v), .i_d0(rec), .i_wr1(fin_v), .i_d1(fin),
        .i_rd(pop), .o_q(q), .o_empty(empty), .o_almost_full(full)
    );

    assign o_result_kind = q.kind;
    assign o_dep_image = q.dep_image;
    assign o_min_major = q.min_major;
    assign o_min_minor = q.min_minor;
    assign o_min_revision = q.min_revision;
    assign o_min_build = q.min_build;
    assign o_parse_status = q.status;
    assign o_is_last = q.last;
endmodule
`default_nettype wire

// ----- sv/btw_checker.sv -----
// port-level checker for the tlv dependency walker, bound to the top level
// depends on the top level's port list only
`default_nettype none
module btw_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic       o_result_kind,
    input wire logic [2:0] o_parse_status,
    input wire logic       o_is_last
);
    // final status marks itself as last
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result_kind == o_is_last)) else $error("kind/last mismatch");
    // records carry no status
    a_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result_kind) |-> (o_parse_status == 3'd0))
        else $error("record with status");
    // held result stays while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_is_last))) else $error("result dropped");
    // in the cycle after a reset cycle the queue is empty and not full
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("bad reset");
endmodule

bind boot_image_tlv_dependency_walker btw_checker u_chk (
    .i_clk, .i_rst_n, .full, .empty, .pop, .o_result_kind, .o_parse_status, .o_is_last
);
`default_nettype wire
